FILE: rtl/retransmit_tracking_table_unit_defines.svh
// Assertion macros for the retransmit tracking table.
`ifndef RETRANSMIT_TRACKING_TABLE_UNIT_DEFINES_SVH
`define RETRANSMIT_TRACKING_TABLE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define RTTU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define RTTU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/rttu_pkg.sv
// Shared types and constants of the retransmit tracking table.
`default_nettype none
package rttu_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 16;
  localparam int MAX_RESULTS         = 16;
  localparam int RES_CNT_W           = $clog2(MAX_RESULTS + 1);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT = 1'b1;

  localparam logic [31:0] TIMEOUT_RESET     = 32'd100;
  localparam logic [3:0]  RETRY_LIMIT_RESET = 4'd3;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_ACK   = 2'd1,
    CMD_CHECK = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    EV_ADDED    = 3'd0,
    EV_EMPTY    = 3'd1,
    EV_FULL     = 3'd2,
    EV_ACKED    = 3'd3,
    EV_NOTFOUND = 3'd4,
    EV_RESEND   = 3'd5,
    EV_DROPPED  = 3'd6,
    EV_IDLE     = 3'd7
  } ev_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] len;
    logic [31:0] sent_at;
    logic [3:0]  retries;
  } entry_t;

  typedef struct packed {
    ev_t         ev;
    logic [31:0] id;
    logic [15:0] len;
    logic [3:0]  retries;
  } res_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/retransmit_tracking_table_unit.sv
// Retransmit tracking table: top level with control and the slot chain.
//
// Input channel (in_valid/in_ready) carries one command per transaction:
// add, acknowledge or check. Each command yields one or more results on the
// output channel (out_valid/out_ready); last marks the final one. Command 3
// is dropped silently.
// An add result enters the holding register on acceptance and moves to the
// output register from the flush state. Ack and check rotate the slot
// chain one entry per cycle while the walk is not held, through the head
// cell, whose entry gets the id compare or the timeout compare; the last
// result is registered from the flush state after the walk. A new command
// is taken only after the last result of the previous one sits in the
// output register.
// Results pass through a one-entry holding register so the last flag is
// known when a result leaves; a stalled receiver holds the walk whenever a
// new result meets both registers full. At most 16 results per command are
// reported; later due entries are still processed.
// Synchronous reset empties the table and restores timeout 100 and retry
// limit 3; slot contents are not cleared. Configuration writes take effect
// at once and belong in idle periods.
`default_nettype none
`include "retransmit_tracking_table_unit_defines.svh"
module retransmit_tracking_table_unit #(
  parameter int TABLE_DEPTH = rttu_pkg::DEFAULT_TABLE_DEPTH
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           cfg_wr_en,
  input  wire [rttu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [31:0]                    cfg_data,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire [1:0]                     command,
  input  wire [31:0]                    msg_id,
  input  wire [15:0]                    msg_len,
  input  wire [31:0]                    now,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [2:0]                    event_res,
  output logic [31:0]                   event_id,
  output logic [15:0]                   event_len,
  output logic [3:0]                    event_retries,
  output logic                          last
);
  import rttu_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = $clog2(TABLE_DEPTH);

  state_t state, state_next;

  logic [31:0]          timeout_ticks;
  logic [3:0]           retry_limit;
  cmd_t                 cmd_q;
  logic [31:0]          id_q;
  logic [31:0]          now_q;
  logic [CW-1:0]        occ;
  logic [CW-1:0]        walk_n;
  logic [CW-1:0]        walk_i;
  logic                 hit;
  logic [RES_CNT_W-1:0] res_cnt;
  logic                 pend_valid;
  res_t                 pend;
  res_t                 out_res;
  logic                 out_last;

  entry_t     entries [TABLE_DEPTH];
  cell_ctrl_t ctrl    [TABLE_DEPTH];
  entry_t     head;

  logic          accept;
  logic          out_free;
  logic          out_load;
  logic          add_ok;
  res_t          add_res;
  logic [CW-1:0] occ_m1;
  logic [31:0]   elapsed;
  logic          walk_active;
  logic          step_emit;
  logic          step_keep;
  logic          step_report;
  logic          step_go;
  res_t          step_res;
  entry_t        step_entry;
  res_t          flush_res;
  logic          load_en;
  logic [IW-1:0] load_idx;
  entry_t        load_entry;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign head     = entries[0];
  assign occ_m1   = occ - CW'(1);
  assign elapsed  = now_q - head.sent_at;
  // output register takes the held result or the closing result
  assign out_load = (step_go && step_report && pend_valid) ||
                    ((state == ST_FLUSH) && out_free);

  // slot chain, head at index 0
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    entry_t nbr;
    if (g == TABLE_DEPTH - 1) begin : g_tail
      assign nbr = entries[g];
    end else begin : g_mid
      assign nbr = entries[g + 1];
    end
    assign ctrl[g].shift = step_go;
    assign ctrl[g].load  = load_en && (load_idx == IW'(g));
    rttu_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl[g]),
      .load_entry (load_entry),
      .nbr_entry  (nbr),
      .entry      (entries[g])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_t'(command))
            CMD_ADD:   state_next = ST_FLUSH;
            CMD_ACK:   state_next = ST_WALK;
            CMD_CHECK: state_next = ST_WALK;
            CMD_NONE:  state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_WALK: begin
        if (walk_i == walk_n) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // add decision
  always_comb begin
    add_ok  = 1'b0;
    add_res = '{ev: EV_ADDED, id: msg_id, len: msg_len, retries: 4'd0};
    if (msg_len == 16'd0) begin
      add_res.ev  = EV_EMPTY;
      add_res.len = 16'd0;
    end else if (occ >= CW'(TABLE_DEPTH)) begin
      add_res.ev = EV_FULL;
    end else begin
      add_ok = 1'b1;
    end
  end

  // one walk step on the head entry
  always_comb begin
    walk_active = (state == ST_WALK) && (walk_i != walk_n);
    step_entry  = head;
    step_emit   = 1'b0;
    step_keep   = 1'b1;
    step_res    = '{ev: EV_ACKED, id: head.id, len: head.len, retries: head.retries};
    if (cmd_q == CMD_ACK) begin
      if (!hit && (head.id == id_q)) begin
        step_emit = 1'b1;
        step_keep = 1'b0;
      end
    end else if (elapsed > timeout_ticks) begin
      step_emit = 1'b1;
      if (head.retries < retry_limit) begin
        step_entry.sent_at = now_q;
        step_entry.retries = head.retries + 4'd1;
        step_res.ev        = EV_RESEND;
        step_res.retries   = head.retries + 4'd1;
      end else begin
        step_keep   = 1'b0;
        step_res.ev = EV_DROPPED;
      end
    end
    step_report = step_emit && (res_cnt < RES_CNT_W'(MAX_RESULTS));
    // both result registers full and the receiver stalled: hold the walk
    step_go     = walk_active && !(step_report && pend_valid && !out_free);
  end

  // slot write bus and closing result
  always_comb begin
    load_en    = 1'b0;
    load_idx   = occ_m1[IW-1:0];
    load_entry = step_entry;
    if (accept && (cmd_t'(command) == CMD_ADD) && add_ok) begin
      load_en    = 1'b1;
      load_idx   = occ[IW-1:0];
      load_entry = '{id: msg_id, len: msg_len, sent_at: now, retries: 4'd0};
    end else if (step_go && step_keep) begin
      load_en = 1'b1;
    end
    if (cmd_q == CMD_ACK) begin
      flush_res = '{ev: EV_NOTFOUND, id: id_q, len: 16'd0, retries: 4'd0};
    end else begin
      flush_res = '{ev: EV_IDLE, id: 32'd0, len: 16'd0, retries: 4'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      timeout_ticks <= TIMEOUT_RESET;
      retry_limit   <= RETRY_LIMIT_RESET;
      occ           <= '0;
      walk_n        <= '0;
      walk_i        <= '0;
      hit           <= 1'b0;
      res_cnt       <= '0;
      pend_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_TIMEOUT:     timeout_ticks <= cfg_data;
          REG_RETRY_LIMIT: retry_limit   <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        cmd_q   <= cmd_t'(command);
        id_q    <= msg_id;
        now_q   <= now;
        walk_n  <= occ;
        walk_i  <= '0;
        hit     <= 1'b0;
        res_cnt <= '0;
        if (cmd_t'(command) == CMD_ADD) begin
          pend       <= add_res;
          pend_valid <= 1'b1;
          if (add_ok) occ <= occ + CW'(1);
        end
      end
      if (step_go) begin
        walk_i <= walk_i + CW'(1);
        if (step_emit) hit <= 1'b1;
        if (!step_keep) occ <= occ_m1;
        if (step_report) begin
          res_cnt    <= res_cnt + RES_CNT_W'(1);
          pend       <= step_res;
          pend_valid <= 1'b1;
          if (pend_valid) begin
            out_res  <= pend;
            out_last <= 1'b0;
          end
        end
      end
      if ((state == ST_FLUSH) && out_free) begin
        out_res    <= pend_valid ? pend : flush_res;
        out_last   <= 1'b1;
        pend_valid <= 1'b0;
      end
    end
  end

  assign event_res     = out_res.ev;
  assign event_id      = out_res.id;
  assign event_len     = out_res.len;
  assign event_retries = out_res.retries;
  assign last          = out_last;

  `RTTU_ASSERT_NOW(a_occ_bound, 1'b1, occ <= CW'(TABLE_DEPTH), "occupancy beyond table depth")
  `RTTU_ASSERT_NOW(a_idle_pend_empty, in_ready, !pend_valid, "held result while taking a command")
  `RTTU_ASSERT_NOW(a_walk_bound, state == ST_WALK, walk_i <= walk_n, "walk ran past its entries")
  `RTTU_ASSERT_NEXT(a_flush_last, (state == ST_FLUSH) && out_free, out_valid && out_last,
    "closing result not marked last")

endmodule
`default_nettype wire

FILE: rtl/rttu_cell.sv
// One table slot: holds an entry, loads from the write bus or shifts from its neighbor.
`default_nettype none
module rttu_cell (
  input  wire                  clk,
  input  rttu_pkg::cell_ctrl_t ctrl,
  input  rttu_pkg::entry_t     load_entry,
  input  rttu_pkg::entry_t     nbr_entry,
  output rttu_pkg::entry_t     entry
);
  import rttu_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      entry <= load_entry;
    end else if (ctrl.shift) begin
      entry <= nbr_entry;
    end
  end

endmodule
`default_nettype wire

FILE: verif/tracking_table_checker.sv
// Checker for the retransmit tracking table: predicts events per command and compares.
`timescale 1ns / 100ps
module tracking_table_checker
  import rttu_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [1:0]           command,
  input  logic [31:0]          msg_id,
  input  logic [15:0]          msg_len,
  input  logic [31:0]          now,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [2:0]           event_res,
  input  logic [31:0]          event_id,
  input  logic [15:0]          event_len,
  input  logic [3:0]           event_retries,
  input  logic                 last,
  output int                   failures,
  output int                   pending
);

  typedef struct packed {
    ev_t         ev;
    logic [31:0] id;
    logic [15:0] len;
    logic [3:0]  retries;
    logic        last;
  } table_event_t;

  logic [31:0]  timeout_q;
  logic [3:0]   limit_q;
  entry_t       slots [TABLE_DEPTH];
  int           fill;
  table_event_t batch [$];
  table_event_t awaited_events [$];
  table_event_t head;

  initial begin
    failures = 0;
    pending  = 0;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    failures++;
  endtask

  function automatic void log_event(ev_t ev, logic [31:0] id, logic [15:0] len,
                                    logic [3:0] retries);
    if (batch.size() < MAX_RESULTS) batch.push_back('{ev, id, len, retries, 1'b0});
  endfunction

  // remove one entry and shift the tail down
  function automatic void close_gap(int pos);
    for (int i = pos; i + 1 < fill; i++) slots[i] = slots[i + 1];
    fill--;
  endfunction

  task automatic apply_command(cmd_t c, logic [31:0] id, logic [15:0] len, logic [31:0] t);
    int          i;
    bit          hit;
    logic [31:0] elapsed;
    batch.delete();
    case (c)
      CMD_ADD: begin
        if (len == 16'd0) begin
          log_event(EV_EMPTY, id, 16'd0, 4'd0);
        end else if (fill >= TABLE_DEPTH) begin
          log_event(EV_FULL, id, len, 4'd0);
        end else begin
          slots[fill] = '{id, len, t, 4'd0};
          fill++;
          log_event(EV_ADDED, id, len, 4'd0);
        end
      end
      CMD_ACK: begin
        hit = 1'b0;
        for (i = 0; i < fill && !hit; i++) begin
          if (slots[i].id == id) begin
            log_event(EV_ACKED, id, slots[i].len, slots[i].retries);
            close_gap(i);
            hit = 1'b1;
          end
        end
        if (!hit) log_event(EV_NOTFOUND, id, 16'd0, 4'd0);
      end
      CMD_CHECK: begin
        hit = 1'b0;
        i = 0;
        while (i < fill) begin
          elapsed = t - slots[i].sent_at;  // wraps at 32 bits
          if (elapsed > timeout_q) begin
            hit = 1'b1;
            if (slots[i].retries < limit_q) begin
              slots[i].sent_at = t;
              slots[i].retries = slots[i].retries + 4'd1;
              log_event(EV_RESEND, slots[i].id, slots[i].len, slots[i].retries);
              i++;
            end else begin
              log_event(EV_DROPPED, slots[i].id, slots[i].len, slots[i].retries);
              close_gap(i);
            end
          end else begin
            i++;
          end
        end
        if (!hit) log_event(EV_IDLE, 32'd0, 16'd0, 4'd0);
      end
      default: ;
    endcase
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[k]) awaited_events.push_back(batch[k]);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      timeout_q = TIMEOUT_RESET;
      limit_q   = RETRY_LIMIT_RESET;
      fill      = 0;
      awaited_events.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_TIMEOUT:     timeout_q = cfg_data;
          REG_RETRY_LIMIT: limit_q   = cfg_data[3:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (awaited_events.size() == 0) begin
          report("unexpected result, event_res", {29'd0, event_res}, 32'd0);
        end else begin
          head = awaited_events.pop_front();
          if (event_res !== head.ev)          report("event_res", {29'd0, event_res},
                                                     {29'd0, head.ev});
          if (event_id !== head.id)           report("event_id", event_id, head.id);
          if (event_len !== head.len)         report("event_len", {16'd0, event_len},
                                                     {16'd0, head.len});
          if (event_retries !== head.retries) report("event_retries", {28'd0, event_retries},
                                                     {28'd0, head.retries});
          if (last !== head.last)             report("last", {31'd0, last}, {31'd0, head.last});
        end
      end
      if (in_valid && in_ready) apply_command(cmd_t'(command), msg_id, msg_len, now);
    end
    pending = awaited_events.size();
  end

endmodule

FILE: verif/tb_retransmit_tracking_table_unit.sv
// Testbench top for the retransmit tracking table: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_retransmit_tracking_table_unit;
  import rttu_pkg::*;

  localparam int DEPTH = DEFAULT_TABLE_DEPTH;

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           command;
  logic [31:0]          msg_id;
  logic [15:0]          msg_len;
  logic [31:0]          now;
  logic                 out_valid;
  logic                 out_ready;
  logic [2:0]           event_res;
  logic [31:0]          event_id;
  logic [15:0]          event_len;
  logic [3:0]           event_retries;
  logic                 last;
  int                   failures;
  int                   pending;

  bit                   steady_in;
  bit                   steady_out;
  logic [31:0]          tick;
  logic [31:0]          recent_ids [8];
  int                   id_wr;

  retransmit_tracking_table_unit #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .msg_id(msg_id), .msg_len(msg_len), .now(now),
    .out_valid(out_valid), .out_ready(out_ready),
    .event_res(event_res), .event_id(event_id), .event_len(event_len),
    .event_retries(event_retries), .last(last)
  );

  tracking_table_checker #(.TABLE_DEPTH(DEPTH)) u_checker (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .msg_id(msg_id), .msg_len(msg_len), .now(now),
    .out_valid(out_valid), .out_ready(out_ready),
    .event_res(event_res), .event_id(event_id), .event_len(event_len),
    .event_retries(event_retries), .last(last),
    .failures(failures), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #6ms;
    $display("status: fail");
    $finish;
  end

  // one command transaction; called and returns just after a falling edge
  task automatic issue(cmd_t c, logic [31:0] id, logic [15:0] len, logic [31:0] t);
    int gap;
    gap = steady_in ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    command  = c;
    msg_id   = id;
    msg_len  = len;
    now      = t;
    in_valid = 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
  endtask

  // hold the sender until every predicted event is out, then let a dropped command finish
  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic apply_settings(logic [31:0] tmo, logic [3:0] lim);
    cfg_wr_en = 1'b1;
    cfg_index = REG_TIMEOUT;
    cfg_data  = tmo;
    @(negedge clk);
    cfg_index = REG_RETRY_LIMIT;
    cfg_data  = {28'd0, lim};
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic logic [31:0] fresh_id();
    return ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 7)) : 32'($urandom);
  endfunction

  initial begin : receiver
    int stall;
    out_ready = 1'b0;
    forever begin
      stall = steady_out ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int          ph;
    int          sent;
    int          pick;
    int          pace;
    bit          held;
    logic [31:0] tmo;
    logic [3:0]  lim;
    logic [31:0] id;
    logic [15:0] len;
    logic [31:0] base;

    rst       = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = REG_TIMEOUT;
    cfg_data  = 32'd0;
    in_valid  = 1'b0;
    command   = CMD_ADD;
    msg_id    = 32'd0;
    msg_len   = 16'd0;
    now       = 32'd0;
    id_wr     = 0;
    foreach (recent_ids[k]) recent_ids[k] = $urandom;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // directed: empty table, zero length, fill to full across the time wrap
    base = 32'hFFFF_FFC0;
    issue(CMD_CHECK, $urandom, 16'($urandom), base);
    issue(CMD_ACK, 32'hFFFF_FFFF, 16'hFFFF, 32'd0);
    issue(CMD_ADD, 32'hFFFF_FFFF, 16'd0, base);
    for (int i = 0; i < DEPTH; i++) begin
      id  = (i == DEPTH - 1) ? 32'hFFFF_FFFF : 32'(i % 5);
      len = (i == 0) ? 16'hFFFF : 16'(i + 1);
      issue(CMD_ADD, id, len, base + 32'(i * 8));
    end
    issue(CMD_ADD, 32'h1234_5678, 16'h8000, base);
    issue(CMD_NONE, $urandom, 16'($urandom), $urandom);
    issue(CMD_ACK, 32'd2, 16'($urandom), $urandom);  // first of several matching entries
    issue(CMD_CHECK, $urandom, 16'($urandom), 32'h0000_0060);
    issue(CMD_CHECK, $urandom, 16'($urandom), 32'h0000_0060 + 32'd400);
    tick = 32'h0000_0200;

    for (ph = 0; ph < 7; ph++) begin
      settle();
      case (ph)
        0:       begin tmo = 32'd0;         lim = 4'd0;  end
        1:       begin tmo = 32'hFFFF_FFFF; lim = 4'd15; end
        2:       begin tmo = 32'd3;         lim = 4'd15; end
        3:       begin tmo = 32'd100;       lim = 4'd3;  end
        4:       begin tmo = 32'd40;        lim = 4'd1;  end
        5:       begin tmo = $urandom_range(1, 300); lim = 4'($urandom_range(0, 15)); end
        default: begin tmo = $urandom;      lim = 4'($urandom_range(0, 15)); end
      endcase
      apply_settings(tmo, lim);
      steady_in  = (ph == 2) || (ph == 5);
      steady_out = (ph == 2) || (ph == 4);
      pace = (tmo > 32'd3000) ? 1000 : int'(tmo / 3) + 2;
      sent = 0;
      held = 1'b0;
      while (sent < 50) begin
        if (sent == 25 && ph % 2 == 1 && !held) begin
          settle();
          held = 1'b1;
        end
        tick = tick + (($urandom_range(0, 14) == 0) ? 32'($urandom)
                                                     : 32'($urandom_range(0, pace)));
        pick = $urandom_range(0, 99);
        if (pick < 42) begin
          id = fresh_id();
          if (pick < 4)                         len = 16'd0;
          else if ($urandom_range(0, 9) == 0)   len = 16'hFFFF;
          else                                  len = 16'($urandom_range(1, 65535));
          recent_ids[3'(id_wr % 8)] = id;
          id_wr++;
          issue(CMD_ADD, id, len, tick);
          sent++;
        end else if (pick < 66) begin
          id = ($urandom_range(0, 3) != 0) ? recent_ids[3'($urandom_range(0, 7))] : $urandom;
          issue(CMD_ACK, id, 16'($urandom), $urandom);
          sent++;
        end else if (pick < 95) begin
          // an occasional stray time stamp lands far ahead or behind the entries
          issue(CMD_CHECK, $urandom, 16'($urandom),
                ($urandom_range(0, 19) == 0) ? 32'($urandom) : tick);
          sent++;
        end else begin
          issue(CMD_NONE, $urandom, 16'($urandom), $urandom);
        end
      end
    end

    settle();
    if (failures == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
